@@ sv/urfi_pkg.sv @@
// Package for the UART register block: payload structs, register offsets,
// request codes, masks and the receive/transmit level table. No dependencies.
package urfi_pkg;

    localparam int FIFO_DEPTH = 32;
    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_TICK  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    localparam logic [4:0] REG_DATA  = 5'd0;
    localparam logic [4:0] REG_RSR   = 5'd1;
    localparam logic [4:0] REG_FLAG  = 5'd6;
    localparam logic [4:0] REG_ILPR  = 5'd8;
    localparam logic [4:0] REG_IBRD  = 5'd9;
    localparam logic [4:0] REG_FBRD  = 5'd10;
    localparam logic [4:0] REG_LCR   = 5'd11;
    localparam logic [4:0] REG_CR    = 5'd12;
    localparam logic [4:0] REG_IFLS  = 5'd13;
    localparam logic [4:0] REG_IMSC  = 5'd14;
    localparam logic [4:0] REG_RIS   = 5'd15;
    localparam logic [4:0] REG_MIS   = 5'd16;
    localparam logic [4:0] REG_ICR   = 5'd17;
    localparam logic [4:0] REG_DMACR = 5'd18;

    localparam logic [9:0]  LCR_MASK_R1 = 10'h3ff;
    localparam logic [9:0]  LCR_MASK_R0 = 10'h0ff;
    localparam logic [15:0] CR_MASK_R1  = 16'hcb87;
    localparam logic [15:0] CR_MASK_R0  = 16'h0381;
    localparam logic [10:0] IM_MASK_R1  = 11'h7f2;
    localparam logic [10:0] IM_MASK_R0  = 11'h7f0;
    localparam logic [10:0] IRQ_RX_MASK = 11'h050;
    localparam logic [10:0] IRQ_TX_MASK = 11'h020;
    localparam logic [15:0] CR_RESET    = 16'h0300;
    localparam logic [5:0]  IFLS_RESET  = 6'h12;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [4:0]  reg_index;
        logic [31:0] write_data;
        logic        rx_valid;
        logic [15:0] rx_char;
    } t_in;

    typedef struct packed {
        logic [31:0] read_data;
        logic        access_error;
        logic        tx_valid;
        logic [8:0]  tx_char;
        logic        irq_combined;
        logic        irq_rx;
        logic        irq_tx;
        logic        dma_rx_req;
        logic        dma_tx_req;
    } t_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_OUT
    } t_state;

    function automatic logic [3:0] level_eighths(input logic [2:0] sel);
        case (sel)
            3'd0: level_eighths = 4'd1;
            3'd1: level_eighths = 4'd2;
            3'd2: level_eighths = 4'd4;
            3'd3: level_eighths = 4'd6;
            3'd4: level_eighths = 4'd7;
            default: level_eighths = 4'd8;
        endcase
    endfunction

endpackage

@@ sv/urfi_ram.sv @@
// Generic single-port-write, single-read RAM with a registered read.
// No dependencies.
module urfi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ sv/uart_registers_fifos_irq_core.sv @@
// Top level of the UART register block: control sequencer, registers and
// two FIFO memories. Depends on urfi_pkg and urfi_ram.
//
// Usage: i_in_valid/o_in_ready carry one request beat (bus read, bus write
// or tick). o_out_valid/i_out_ready return exactly one result beat per
// request. i_cfg_valid/o_cfg_ready write soc_rev; write it only while idle.
// A request goes through three steps: accept, execute (the FIFO memories
// present the head entries read in the accept cycle, and the registers
// and FIFO pointers are updated), and hand-off to the output register.
// The result is held in the output register until taken; a new request is
// accepted in the cycle after the result is taken, so the block takes no
// new request while a result is pending or in execution.
// A stalled receiver simply holds the block with its result pending.
// Reset loads control/status reset values and clears counts and pointers;
// FIFO contents are undefined until written and need no clearing pass.
module uart_registers_fifos_irq_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  urfi_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output urfi_pkg::t_out  o_out_data,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic            i_cfg_data
);

    localparam int PW = urfi_pkg::PTR_W;
    localparam int CW = urfi_pkg::CNT_W;

    urfi_pkg::t_state r_state, n_state;
    urfi_pkg::t_in    r_req;
    urfi_pkg::t_out   r_out, n_out;

    logic          r_soc_rev;
    logic [PW-1:0] r_tx_head, n_tx_head, r_rx_head, n_rx_head;
    logic [CW-1:0] r_tx_cnt, n_tx_cnt, r_rx_cnt, n_rx_cnt;
    logic [9:0]    r_lcr, n_lcr;
    logic [15:0]   r_cr, n_cr;
    logic [5:0]    r_ifls, n_ifls;
    logic [10:0]   r_imsc, n_imsc, r_ris, n_ris;
    logic [2:0]    r_dmacr, n_dmacr;
    logic [15:0]   r_ibrd, n_ibrd;
    logic [5:0]    r_fbrd, n_fbrd;
    logic [7:0]    r_ilpr, n_ilpr;

    logic          tx_we, rx_we;
    logic [PW-1:0] tx_waddr, rx_waddr;
    logic [8:0]    tx_wdata, tx_rdata;
    logic [15:0]   rx_wdata, rx_rdata;

    urfi_ram #(.WIDTH(9), .DEPTH(urfi_pkg::FIFO_DEPTH)) u_tx_ram (
        .i_clk(i_clk), .i_we(tx_we), .i_waddr(tx_waddr), .i_wdata(tx_wdata),
        .i_raddr(r_tx_head), .o_rdata(tx_rdata)
    );

    urfi_ram #(.WIDTH(16), .DEPTH(urfi_pkg::FIFO_DEPTH)) u_rx_ram (
        .i_clk(i_clk), .i_we(rx_we), .i_waddr(rx_waddr), .i_wdata(rx_wdata),
        .i_raddr(r_rx_head), .o_rdata(rx_rdata)
    );

    assign o_in_ready  = (r_state == urfi_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = (r_state == urfi_pkg::ST_OUT);
    assign o_out_data  = r_out;

    function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] h,
                                               input logic [CW-1:0] c);
        logic [CW:0] s;
        s = {{(CW + 1 - PW){1'b0}}, h} + {1'b0, c};
        if (s >= (CW + 1)'(urfi_pkg::FIFO_DEPTH)) begin
            s = s - (CW + 1)'(urfi_pkg::FIFO_DEPTH);
        end
        wrap_add = s[PW-1:0];
    endfunction

    function automatic logic [PW-1:0] inc_ptr(input logic [PW-1:0] h);
        inc_ptr = (h == PW'(urfi_pkg::FIFO_DEPTH - 1)) ? '0 : h + 1'b1;
    endfunction

    always_comb begin
        logic [CW-1:0] size;
        logic [CW+3:0] rx_prod, tx_prod;
        logic [CW-1:0] rx_th, tx_th, free_tx;
        logic          ok, wr, eval, done, have_rx, cr_ok, lb;
        logic [15:0]   rx_in;
        logic [8:0]    ch;
        logic [31:0]   rd;
        logic [10:0]   masked;

        n_state   = r_state;
        n_out     = r_out;
        n_tx_head = r_tx_head;
        n_rx_head = r_rx_head;
        n_tx_cnt  = r_tx_cnt;
        n_rx_cnt  = r_rx_cnt;
        n_lcr     = r_lcr;
        n_cr      = r_cr;
        n_ifls    = r_ifls;
        n_imsc    = r_imsc;
        n_ris     = r_ris;
        n_dmacr   = r_dmacr;
        n_ibrd    = r_ibrd;
        n_fbrd    = r_fbrd;
        n_ilpr    = r_ilpr;
        tx_we     = 1'b0;
        rx_we     = 1'b0;
        tx_waddr  = wrap_add(r_tx_head, r_tx_cnt);
        rx_waddr  = wrap_add(r_rx_head, r_rx_cnt);
        tx_wdata  = '0;
        rx_wdata  = '0;
        ok = 1'b1; eval = 1'b0; done = 1'b0; have_rx = 1'b0;
        rx_in = '0; rd = '0; ch = '0;
        wr = (r_req.req_type == urfi_pkg::REQ_WRITE);
        size = '0; rx_prod = '0; tx_prod = '0; rx_th = '0; tx_th = '0;
        free_tx = '0; cr_ok = 1'b0; lb = 1'b0; masked = '0;

        case (r_state)
            urfi_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = urfi_pkg::ST_EXEC;
                end
            end
            urfi_pkg::ST_EXEC: begin
                size = !r_lcr[4] ? CW'(1) : r_soc_rev ? CW'(urfi_pkg::FIFO_DEPTH)
                                                    : CW'(urfi_pkg::FIFO_DEPTH / 2);
                if (r_req.req_type == urfi_pkg::REQ_READ || wr) begin
                    case (r_req.reg_index)
                        urfi_pkg::REG_DATA: begin
                            if (wr) begin
                                ch = {1'b0, r_req.write_data[7:0]};
                                if (r_lcr[9]) begin
                                    ch[8] = r_lcr[8];
                                    n_lcr[8] = 1'b0;
                                end
                                if (r_tx_cnt >= size) begin
                                    ok = 1'b0;
                                end else begin
                                    tx_we = 1'b1;
                                    tx_wdata = ch;
                                    n_tx_cnt = r_tx_cnt + 1'b1;
                                    eval = 1'b1;
                                end
                            end else if (r_rx_cnt == '0) begin
                                ok = 1'b0;
                            end else begin
                                rd = {16'd0, rx_rdata};
                                n_rx_head = inc_ptr(r_rx_head);
                                n_rx_cnt = r_rx_cnt - 1'b1;
                            end
                        end
                        urfi_pkg::REG_RSR: eval = wr;
                        urfi_pkg::REG_FLAG: begin
                            if (wr) begin
                                ok = 1'b0;
                            end else begin
                                rd[7] = (r_tx_cnt == '0);
                                rd[6] = (r_rx_cnt >= size);
                                rd[5] = (r_tx_cnt >= size);
                                rd[4] = (r_rx_cnt == '0);
                                rd[3] = (r_tx_cnt != '0);
                            end
                        end
                        urfi_pkg::REG_ILPR: begin
                            if (!r_soc_rev) ok = 1'b0;
                            else if (wr) n_ilpr = r_req.write_data[7:0];
                            else rd = {24'd0, r_ilpr};
                        end
                        urfi_pkg::REG_IBRD: begin
                            if (wr) n_ibrd = r_req.write_data[15:0];
                            else rd = {16'd0, r_ibrd};
                        end
                        urfi_pkg::REG_FBRD: begin
                            if (wr) n_fbrd = r_req.write_data[5:0];
                            else rd = {26'd0, r_fbrd};
                        end
                        urfi_pkg::REG_LCR: begin
                            if (wr) begin
                                if (r_lcr[4] != r_req.write_data[4]) begin
                                    n_tx_cnt = '0;
                                    n_rx_cnt = '0;
                                end
                                n_lcr = r_req.write_data[9:0] & (r_soc_rev ?
                                    urfi_pkg::LCR_MASK_R1 : urfi_pkg::LCR_MASK_R0);
                                eval = 1'b1;
                            end else rd = {22'd0, r_lcr};
                        end
                        urfi_pkg::REG_CR: begin
                            if (wr) begin
                                n_cr = r_req.write_data[15:0] & (r_soc_rev ?
                                    urfi_pkg::CR_MASK_R1 : urfi_pkg::CR_MASK_R0);
                                eval = 1'b1;
                            end else rd = {16'd0, r_cr};
                        end
                        urfi_pkg::REG_IFLS: begin
                            if (wr) begin
                                n_ifls = r_req.write_data[5:0];
                                eval = 1'b1;
                            end else rd = {26'd0, r_ifls};
                        end
                        urfi_pkg::REG_IMSC: begin
                            if (wr) begin
                                n_imsc = r_req.write_data[10:0] & (r_soc_rev ?
                                    urfi_pkg::IM_MASK_R1 : urfi_pkg::IM_MASK_R0);
                                eval = 1'b1;
                            end else rd = {21'd0, r_imsc};
                        end
                        urfi_pkg::REG_RIS: begin
                            if (wr) ok = 1'b0;
                            else rd = {21'd0, r_ris};
                        end
                        urfi_pkg::REG_MIS: begin
                            if (wr) ok = 1'b0;
                            else rd = {21'd0, r_ris & r_imsc};
                        end
                        urfi_pkg::REG_ICR: begin
                            if (!wr) ok = 1'b0;
                            else begin
                                n_ris = r_ris & ~r_req.write_data[10:0];
                                eval = 1'b1;
                            end
                        end
                        urfi_pkg::REG_DMACR: begin
                            if (wr) begin
                                n_dmacr = r_req.write_data[2:0];
                                eval = 1'b1;
                            end else rd = {29'd0, r_dmacr};
                        end
                        default: ok = 1'b0;
                    endcase
                end else if (r_req.req_type == urfi_pkg::REQ_TICK && r_cr[0]) begin
                    lb = r_cr[9] && r_cr[7];
                    if (r_cr[8] && r_tx_cnt != '0) begin
                        n_out.tx_valid = 1'b1;
                        ch = tx_rdata;
                        n_tx_head = inc_ptr(r_tx_head);
                        n_tx_cnt = r_tx_cnt - 1'b1;
                        if (lb) begin
                            have_rx = 1'b1;
                            rx_in = {7'd0, tx_rdata};
                        end
                        done = 1'b1;
                    end
                    if (r_cr[9]) begin
                        if (!r_cr[7]) begin
                            have_rx = r_req.rx_valid;
                            rx_in = r_req.rx_char;
                        end
                        if (have_rx) begin
                            if (r_rx_cnt >= size) begin
                                n_ris[10] = 1'b1;
                            end else begin
                                rx_we = 1'b1;
                                rx_wdata = rx_in;
                                n_rx_cnt = r_rx_cnt + 1'b1;
                            end
                            done = 1'b1;
                        end
                    end
                    if (n_rx_cnt != '0 && !n_ris[4]) begin
                        n_ris[6] = 1'b1;
                        done = 1'b1;
                    end
                    eval = done;
                end

                size = !n_lcr[4] ? CW'(1) : r_soc_rev ? CW'(urfi_pkg::FIFO_DEPTH)
                                                    : CW'(urfi_pkg::FIFO_DEPTH / 2);
                rx_th = CW'(1);
                tx_th = CW'(1);
                if (n_lcr[4]) begin
                    rx_prod = (CW + 4)'(urfi_pkg::level_eighths(n_ifls[5:3])) * size;
                    tx_prod = (CW + 4)'(urfi_pkg::level_eighths(n_ifls[2:0])) * size;
                    rx_th = rx_prod[CW+2:3];
                    tx_th = tx_prod[CW+2:3];
                end
                free_tx = (size > n_tx_cnt) ? size - n_tx_cnt : '0;
                if (eval) begin
                    if (n_rx_cnt >= rx_th) n_ris[4] = 1'b1;
                    if (free_tx >= tx_th) n_ris[5] = 1'b1;
                end
                cr_ok = ok;

                masked = n_ris & n_imsc;
                n_out.read_data    = (cr_ok && r_req.req_type == urfi_pkg::REQ_READ)
                                     ? rd : '0;
                n_out.access_error = (r_req.req_type == urfi_pkg::REQ_READ || wr) && !cr_ok;
                n_out.tx_char      = ch;
                if (!n_out.tx_valid) n_out.tx_char = '0;
                n_out.irq_combined = (masked != '0);
                n_out.irq_rx       = ((masked & urfi_pkg::IRQ_RX_MASK) != '0);
                n_out.irq_tx       = ((masked & urfi_pkg::IRQ_TX_MASK) != '0);
                n_out.dma_rx_req   = n_dmacr[2] && n_dmacr[0] && n_ris[4];
                n_out.dma_tx_req   = n_dmacr[2] && n_dmacr[1] && n_ris[5];
                n_state = urfi_pkg::ST_OUT;
            end
            urfi_pkg::ST_OUT: begin
                if (i_out_ready) begin
                    n_state = urfi_pkg::ST_IDLE;
                end
            end
            default: n_state = urfi_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= urfi_pkg::ST_IDLE;
            r_soc_rev <= 1'b1;
            r_tx_head <= '0;
            r_rx_head <= '0;
            r_tx_cnt  <= '0;
            r_rx_cnt  <= '0;
            r_lcr     <= '0;
            r_cr      <= urfi_pkg::CR_RESET;
            r_ifls    <= urfi_pkg::IFLS_RESET;
            r_imsc    <= '0;
            r_ris     <= '0;
            r_dmacr   <= '0;
            r_ibrd    <= '0;
            r_fbrd    <= '0;
            r_ilpr    <= '0;
        end else begin
            r_state   <= n_state;
            r_tx_head <= n_tx_head;
            r_rx_head <= n_rx_head;
            r_tx_cnt  <= n_tx_cnt;
            r_rx_cnt  <= n_rx_cnt;
            r_lcr     <= n_lcr;
            r_cr      <= n_cr;
            r_ifls    <= n_ifls;
            r_imsc    <= n_imsc;
            r_ris     <= n_ris;
            r_dmacr   <= n_dmacr;
            r_ibrd    <= n_ibrd;
            r_fbrd    <= n_fbrd;
            r_ilpr    <= n_ilpr;
            if (i_cfg_valid) begin
                r_soc_rev <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == urfi_pkg::ST_IDLE && i_in_valid) begin
            r_req <= i_in_data;
            r_out <= '0;
        end else begin
            r_out <= n_out;
        end
    end

endmodule

@@ dv/uart_registers_fifos_irq_core_tb.sv @@
// Self-checking testbench for the UART register block with FIFOs and interrupts.
// Drives bus reads, writes and ticks, and checks every result beat against its own predictor.
// Depends on urfi_pkg and on uart_registers_fifos_irq_core.
`timescale 1ns / 100ps

module uart_registers_fifos_irq_core_tb;

    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD = 300;

    typedef struct {
        urfi_pkg::t_in item;
        bit            typed;
        logic [31:0]   rd;
        logic          err;
    } t_row;

    typedef struct {
        urfi_pkg::t_out res;
        bit             typed;
        logic [31:0]    rd;
        logic           err;
    } t_expect;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_in_valid = 1'b0;
    logic           o_in_ready;
    urfi_pkg::t_in  i_in_data = '0;
    logic           o_out_valid;
    logic           i_out_ready = 1'b0;
    urfi_pkg::t_out o_out_data;
    logic           i_cfg_valid = 1'b0;
    logic           o_cfg_ready;
    logic           i_cfg_data = 1'b0;

    uart_registers_fifos_irq_core uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state.
    logic        soc_rev;
    logic [15:0] tx_mem [urfi_pkg::FIFO_DEPTH];
    logic [15:0] rx_mem [urfi_pkg::FIFO_DEPTH];
    int          tx_head, tx_cnt, rx_head, rx_cnt;
    logic [9:0]  lcr;
    logic [15:0] cr;
    logic [5:0]  ifls;
    logic [10:0] imsc, ris;
    logic [2:0]  dmacr;
    logic [15:0] ibrd;
    logic [5:0]  fbrd;
    logic [7:0]  ilpr;

    t_expect    result_q[$];
    t_row       typed_q[$];
    int         errors = 0;
    int         n_items = 0, n_tx = 0;
    bit         no_idle = 1'b0;
    bit         hold_req = 1'b0;
    int         quiet_cycles = 0;
    t_row       dir_rows[$];

    function automatic int fifo_size();
        if (!lcr[4]) return 1;
        return soc_rev ? urfi_pkg::FIFO_DEPTH : urfi_pkg::FIFO_DEPTH / 2;
    endfunction

    function automatic void update_levels();
        int sz, rx_th, tx_th, free_tx;
        int eighths [8] = '{1, 2, 4, 6, 7, 8, 8, 8};
        sz = fifo_size();
        rx_th = 1;
        tx_th = 1;
        if (lcr[4]) begin
            rx_th = eighths[ifls[5:3]] * sz / 8;
            tx_th = eighths[ifls[2:0]] * sz / 8;
        end
        if (rx_cnt >= rx_th) ris[4] = 1'b1;
        free_tx = sz > tx_cnt ? sz - tx_cnt : 0;
        if (free_tx >= tx_th) ris[5] = 1'b1;
    endfunction

    function automatic bit rx_push(logic [15:0] v);
        if (rx_cnt >= fifo_size()) return 1'b0;
        rx_mem[(rx_head + rx_cnt) % urfi_pkg::FIFO_DEPTH] = v;
        rx_cnt++;
        return 1'b1;
    endfunction

    function automatic bit bus_access(bit wr, logic [4:0] idx, logic [31:0] v,
                                      output logic [31:0] rd);
        logic [15:0] ch;
        rd = '0;
        case (idx)
            urfi_pkg::REG_DATA: begin
                if (wr) begin
                    ch = {8'd0, v[7:0]};
                    if (lcr[9]) begin
                        ch[8] = lcr[8];
                        lcr[8] = 1'b0;
                    end
                    if (tx_cnt >= fifo_size()) return 1'b0;
                    tx_mem[(tx_head + tx_cnt) % urfi_pkg::FIFO_DEPTH] = ch;
                    tx_cnt++;
                    update_levels();
                end else begin
                    if (rx_cnt == 0) return 1'b0;
                    rd = 32'(rx_mem[rx_head]);
                    rx_head = (rx_head + 1) % urfi_pkg::FIFO_DEPTH;
                    rx_cnt--;
                end
            end
            urfi_pkg::REG_RSR: if (wr) update_levels();
            urfi_pkg::REG_FLAG: begin
                if (wr) return 1'b0;
                rd[7] = tx_cnt == 0;
                rd[6] = rx_cnt >= fifo_size();
                rd[5] = tx_cnt >= fifo_size();
                rd[4] = rx_cnt == 0;
                rd[3] = tx_cnt != 0;
            end
            urfi_pkg::REG_ILPR: begin
                if (!soc_rev) return 1'b0;
                if (wr) ilpr = v[7:0]; else rd = 32'(ilpr);
            end
            urfi_pkg::REG_IBRD: if (wr) ibrd = v[15:0]; else rd = 32'(ibrd);
            urfi_pkg::REG_FBRD: if (wr) fbrd = v[5:0]; else rd = 32'(fbrd);
            urfi_pkg::REG_LCR: begin
                if (wr) begin
                    if (lcr[4] != v[4]) begin
                        tx_cnt = 0;
                        rx_cnt = 0;
                    end
                    lcr = v[9:0] & (soc_rev ? urfi_pkg::LCR_MASK_R1 : urfi_pkg::LCR_MASK_R0);
                    update_levels();
                end else rd = 32'(lcr);
            end
            urfi_pkg::REG_CR: begin
                if (wr) begin
                    cr = v[15:0] & (soc_rev ? urfi_pkg::CR_MASK_R1 : urfi_pkg::CR_MASK_R0);
                    update_levels();
                end else rd = 32'(cr);
            end
            urfi_pkg::REG_IFLS: begin
                if (wr) begin
                    ifls = v[5:0];
                    update_levels();
                end else rd = 32'(ifls);
            end
            urfi_pkg::REG_IMSC: begin
                if (wr) begin
                    imsc = v[10:0] & (soc_rev ? urfi_pkg::IM_MASK_R1 : urfi_pkg::IM_MASK_R0);
                    update_levels();
                end else rd = 32'(imsc);
            end
            urfi_pkg::REG_RIS: begin
                if (wr) return 1'b0;
                rd = 32'(ris);
            end
            urfi_pkg::REG_MIS: begin
                if (wr) return 1'b0;
                rd = 32'(ris & imsc);
            end
            urfi_pkg::REG_ICR: begin
                if (!wr) return 1'b0;
                ris = ris & ~v[10:0];
                update_levels();
            end
            urfi_pkg::REG_DMACR: begin
                if (wr) begin
                    dmacr = v[2:0];
                    update_levels();
                end else rd = 32'(dmacr);
            end
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic void line_tick(logic rxv, logic [15:0] rxc, ref urfi_pkg::t_out o);
        bit done, have_rx;
        logic [15:0] rx_in, ch;
        done = 1'b0;
        have_rx = 1'b0;
        rx_in = '0;
        if (!cr[0]) return;
        if (cr[8] && tx_cnt != 0) begin
            ch = tx_mem[tx_head];
            tx_head = (tx_head + 1) % urfi_pkg::FIFO_DEPTH;
            tx_cnt--;
            o.tx_valid = 1'b1;
            o.tx_char = ch[8:0];
            if (cr[9] && cr[7]) begin
                have_rx = 1'b1;
                rx_in = ch;
            end
            done = 1'b1;
        end
        if (cr[9]) begin
            if (!cr[7]) begin
                have_rx = rxv;
                rx_in = rxc;
            end
            if (have_rx) begin
                if (!rx_push(rx_in)) ris[10] = 1'b1;
                done = 1'b1;
            end
        end
        if (rx_cnt != 0 && !ris[4]) begin
            ris[6] = 1'b1;
            done = 1'b1;
        end
        if (done) update_levels();
    endfunction

    function automatic urfi_pkg::t_out predict_result(urfi_pkg::t_in it);
        urfi_pkg::t_out o;
        logic [31:0] rd;
        logic [10:0] masked;
        bit ok;
        o = '0;
        if (it.req_type == urfi_pkg::REQ_READ || it.req_type == urfi_pkg::REQ_WRITE) begin
            ok = bus_access(it.req_type == urfi_pkg::REQ_WRITE, it.reg_index,
                            it.write_data, rd);
            o.read_data = (ok && it.req_type == urfi_pkg::REQ_READ) ? rd : '0;
            o.access_error = !ok;
        end else if (it.req_type == urfi_pkg::REQ_TICK) begin
            line_tick(it.rx_valid, it.rx_char, o);
        end
        masked = ris & imsc;
        o.irq_combined = masked != 0;
        o.irq_rx = (masked & urfi_pkg::IRQ_RX_MASK) != 0;
        o.irq_tx = (masked & urfi_pkg::IRQ_TX_MASK) != 0;
        o.dma_rx_req = dmacr[2] && dmacr[0] && ris[4];
        o.dma_tx_req = dmacr[2] && dmacr[1] && ris[5];
        return o;
    endfunction

    function automatic void reset_model();
        soc_rev = 1'b1;
        tx_head = 0; tx_cnt = 0; rx_head = 0; rx_cnt = 0;
        lcr = '0; cr = urfi_pkg::CR_RESET; ifls = urfi_pkg::IFLS_RESET;
        imsc = '0; ris = '0; dmacr = '0; ibrd = '0; fbrd = '0; ilpr = '0;
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_expect e;
        t_row    r;
        bit      moved;
        moved = 1'b0;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            moved = 1'b1;
            r = typed_q.pop_front();
            e.res = predict_result(i_in_data);
            e.typed = r.typed;
            e.rd = r.rd;
            e.err = r.err;
            result_q.push_back(e);
            n_items++;
            if (e.res.tx_valid) n_tx++;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            moved = 1'b1;
            if (result_q.size() == 0) begin
                $error("result beat with no expectation pending");
                errors++;
            end else begin
                e = result_q.pop_front();
                check_field("read_data", e.res.read_data, o_out_data.read_data);
                check_field("access_error", 32'(e.res.access_error),
                            32'(o_out_data.access_error));
                check_field("tx_valid", 32'(e.res.tx_valid), 32'(o_out_data.tx_valid));
                check_field("tx_char", 32'(e.res.tx_char), 32'(o_out_data.tx_char));
                check_field("irq_combined", 32'(e.res.irq_combined),
                            32'(o_out_data.irq_combined));
                check_field("irq_rx", 32'(e.res.irq_rx), 32'(o_out_data.irq_rx));
                check_field("irq_tx", 32'(e.res.irq_tx), 32'(o_out_data.irq_tx));
                check_field("dma_rx_req", 32'(e.res.dma_rx_req), 32'(o_out_data.dma_rx_req));
                check_field("dma_tx_req", 32'(e.res.dma_tx_req), 32'(o_out_data.dma_tx_req));
                if (e.typed) begin
                    check_field("read_data (table)", e.rd, o_out_data.read_data);
                    check_field("access_error (table)", 32'(e.err),
                                32'(o_out_data.access_error));
                end
            end
        end
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            moved = 1'b1;
            soc_rev = i_cfg_data;
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (i_rst_n && quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver side: random stall bursts, one long hold on request, none at the end.
    initial begin
        int run;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready = 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (no_idle || $urandom_range(0, 3) != 0) begin
                i_out_ready = 1'b1;
            end else begin
                i_out_ready = 1'b0;
                run = $urandom_range(1, 16);
                repeat (run - 1) @(negedge i_clk);
            end
        end
    end

    task automatic send_beat(t_row r);
        typed_q.push_back(r);
        i_in_data = r.item;
        i_in_valid = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
        if (!no_idle && $urandom_range(0, 7) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_in_valid = 1'b0;
        while (result_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_rev(logic v);
        i_cfg_data = v;
        i_cfg_valid = 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic t_row mk(urfi_pkg::t_req t, logic [4:0] idx, logic [31:0] wd,
                                logic rxv, logic [15:0] rxc, bit typed, logic [31:0] rd,
                                logic err);
        t_row r;
        r.item.req_type = t;
        r.item.reg_index = idx;
        r.item.write_data = wd;
        r.item.rx_valid = rxv;
        r.item.rx_char = rxc;
        r.typed = typed;
        r.rd = rd;
        r.err = err;
        return r;
    endfunction

    function automatic t_row random_row();
        logic [4:0] regs [13] = '{urfi_pkg::REG_RSR, urfi_pkg::REG_FLAG, urfi_pkg::REG_ILPR,
                                  urfi_pkg::REG_IBRD, urfi_pkg::REG_FBRD, urfi_pkg::REG_LCR,
                                  urfi_pkg::REG_CR, urfi_pkg::REG_IFLS, urfi_pkg::REG_IMSC,
                                  urfi_pkg::REG_RIS, urfi_pkg::REG_MIS, urfi_pkg::REG_ICR,
                                  urfi_pkg::REG_DMACR};
        urfi_pkg::t_req t;
        logic [4:0] idx;
        logic [31:0] wd;
        int p;
        p = $urandom_range(0, 99);
        t = p < 3 ? urfi_pkg::REQ_NONE : p < 40 ? urfi_pkg::REQ_TICK :
            p < 72 ? urfi_pkg::REQ_WRITE : urfi_pkg::REQ_READ;
        p = $urandom_range(0, 99);
        idx = p < 35 ? urfi_pkg::REG_DATA : p < 92 ? regs[$urandom_range(0, 12)]
                                                    : 5'($urandom);
        wd = $urandom;
        if (idx == urfi_pkg::REG_LCR && $urandom_range(0, 9) != 0) wd[4] = 1'b1;
        if (idx == urfi_pkg::REG_CR && $urandom_range(0, 9) != 0) wd = wd | 32'h301;
        return mk(t, idx, wd, 1'($urandom_range(0, 1)), 16'($urandom), 1'b0, '0, 1'b0);
    endfunction

    initial begin
        int n;
        reset_model();
        dir_rows.push_back(mk(urfi_pkg::REQ_READ, urfi_pkg::REG_CR, '0, 1'b0, '0,
                              1'b1, 32'h300, 1'b0));
        dir_rows.push_back(mk(urfi_pkg::REQ_READ, urfi_pkg::REG_IFLS, '0, 1'b0, '0,
                              1'b1, 32'h12, 1'b0));
        dir_rows.push_back(mk(urfi_pkg::REQ_READ, urfi_pkg::REG_FLAG, '0, 1'b0, '0,
                              1'b1, 32'h90, 1'b0));
        dir_rows.push_back(mk(urfi_pkg::REQ_READ, urfi_pkg::REG_DATA, '0, 1'b0, '0,
                              1'b1, '0, 1'b1));
        dir_rows.push_back(mk(urfi_pkg::REQ_WRITE, urfi_pkg::REG_RIS, '1, 1'b0, '0,
                              1'b1, '0, 1'b1));
        dir_rows.push_back(mk(urfi_pkg::REQ_READ, urfi_pkg::REG_ICR, '0, 1'b0, '0,
                              1'b1, '0, 1'b1));
        dir_rows.push_back(mk(urfi_pkg::REQ_READ, 5'd2, '0, 1'b0, '0, 1'b1, '0, 1'b1));
        dir_rows.push_back(mk(urfi_pkg::REQ_WRITE, 5'd31, '1, 1'b0, '0, 1'b1, '0, 1'b1));
        dir_rows.push_back(mk(urfi_pkg::REQ_WRITE, urfi_pkg::REG_LCR, '1, 1'b0, '0,
                              1'b1, '0, 1'b0));
        dir_rows.push_back(mk(urfi_pkg::REQ_READ, urfi_pkg::REG_LCR, '0, 1'b0, '0,
                              1'b1, 32'h3ff, 1'b0));
        dir_rows.push_back(mk(urfi_pkg::REQ_WRITE, urfi_pkg::REG_IMSC, '1, 1'b0, '0,
                              1'b0, '0, 1'b0));
        dir_rows.push_back(mk(urfi_pkg::REQ_WRITE, urfi_pkg::REG_DMACR, '1, 1'b0, '0,
                              1'b0, '0, 1'b0));
        dir_rows.push_back(mk(urfi_pkg::REQ_WRITE, urfi_pkg::REG_DATA, 32'h1ff, 1'b0, '0,
                              1'b0, '0, 1'b0));
        dir_rows.push_back(mk(urfi_pkg::REQ_WRITE, urfi_pkg::REG_CR, '1, 1'b0, '0,
                              1'b0, '0, 1'b0));
        dir_rows.push_back(mk(urfi_pkg::REQ_TICK, '0, '0, 1'b1, '1, 1'b0, '0, 1'b0));
        dir_rows.push_back(mk(urfi_pkg::REQ_READ, urfi_pkg::REG_DATA, '0, 1'b0, '0,
                              1'b0, '0, 1'b0));
        dir_rows.push_back(mk(urfi_pkg::REQ_WRITE, urfi_pkg::REG_ICR, '1, 1'b0, '0,
                              1'b0, '0, 1'b0));
        dir_rows.push_back(mk(urfi_pkg::REQ_WRITE, urfi_pkg::REG_ILPR, '1, 1'b0, '0,
                              1'b1, '0, 1'b0));
        dir_rows.push_back(mk(urfi_pkg::REQ_READ, urfi_pkg::REG_ILPR, '0, 1'b0, '0,
                              1'b1, 32'hff, 1'b0));
        dir_rows.push_back(mk(urfi_pkg::REQ_WRITE, urfi_pkg::REG_IBRD, '1, 1'b0, '0,
                              1'b0, '0, 1'b0));
        dir_rows.push_back(mk(urfi_pkg::REQ_WRITE, urfi_pkg::REG_FBRD, '1, 1'b0, '0,
                              1'b0, '0, 1'b0));
        dir_rows.push_back(mk(urfi_pkg::REQ_READ, urfi_pkg::REG_RSR, '0, 1'b0, '0,
                              1'b1, '0, 1'b0));
        dir_rows.push_back(mk(urfi_pkg::REQ_WRITE, urfi_pkg::REG_RSR, '1, 1'b0, '0,
                              1'b1, '0, 1'b0));
        dir_rows.push_back(mk(urfi_pkg::REQ_NONE, '1, '1, 1'b1, '1, 1'b1, '0, 1'b0));
        dir_rows.push_back(mk(urfi_pkg::REQ_READ, urfi_pkg::REG_MIS, '0, 1'b0, '0,
                              1'b0, '0, 1'b0));

        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        foreach (dir_rows[i]) send_beat(dir_rows[i]);
        drain_results();

        for (n = 0; n < 500; n++) begin
            if (n == 100) hold_req = 1'b1;
            if (n == 300) drain_results();
            send_beat(random_row());
        end
        drain_results();
        write_rev(1'b0);
        for (n = 0; n < 500; n++) send_beat(random_row());
        drain_results();
        write_rev(1'b1);
        for (n = 0; n < 500; n++) begin
            if (n == 350) no_idle = 1'b1;
            send_beat(random_row());
        end
        drain_results();

        $display("Covered %0d beats in three chip-revision phases; %0d characters sent.",
                 n_items, n_tx);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ sim.f @@
sv/urfi_pkg.sv
sv/urfi_ram.sv
sv/uart_registers_fifos_irq_core.sv
dv/uart_registers_fifos_irq_core_tb.sv
